// File: hw/rtl/tsxb_pkg.sv
// Package for the timestamped XOR basis block.
// Holds the field widths, the command codes and the token that travels along the cell chain.
// No dependencies.
package tsxb_pkg;

	localparam int VEC_W    = 64;
	localparam int FIELD_W  = 16;
	localparam int MOD_W    = 31;
	localparam int RANK_W   = 7;
	localparam int STAMP_W  = 32;
	localparam int EXP_W    = 33;

	localparam int VEC_BITS_DEF = 64;
	localparam int IDX_BITS_DEF = 16;

	localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

	typedef enum logic [1:0] {
		CMD_INSERT,
		CMD_CONTAINS,
		CMD_WAYS,
		CMD_UNUSED
	} cmd_t;

	// Control part of the token that walks the cells.
	typedef struct packed {
		logic valid;
		logic alive;
		logic ok;
		logic inserted;
	} tok_t;

endpackage

// File: hw/rtl/tsxb_if.sv
// Valid/ready channel interfaces for the request and the result of the XOR basis block.
// Depends on tsxb_pkg for the field widths.
interface tsxb_req_if import tsxb_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [1:0]          cmd;
	logic [VEC_W-1:0]    vector;
	logic [FIELD_W-1:0]  item_index;
	logic [FIELD_W-1:0]  range_low;
	logic [FIELD_W-1:0]  range_high;

	modport source (output valid, cmd, vector, item_index, range_low, range_high,
		input ready);
	modport sink (input valid, cmd, vector, item_index, range_low, range_high,
		output ready);
endinterface

interface tsxb_rsp_if import tsxb_pkg::*; ;
	logic                valid;
	logic                ready;
	logic                inserted;
	logic                representable;
	logic [MOD_W-1:0]    ways_count;
	logic [RANK_W-1:0]   rank_now;
	logic [FIELD_W-1:0]  last_seen;

	modport source (output valid, inserted, representable, ways_count, rank_now, last_seen,
		input ready);
	modport sink (input valid, inserted, representable, ways_count, rank_now, last_seen,
		output ready);
endinterface

// File: hw/rtl/tsxb_cell.sv
// One basis row of the XOR basis chain: holds the row and its stamp, and reduces the
// passing token by one bit position. Depends on tsxb_pkg.
module tsxb_cell import tsxb_pkg::*; #(
	parameter int VEC_BITS = VEC_BITS_DEF,
	parameter int IDX_BITS = IDX_BITS_DEF,
	parameter int POS      = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [STAMP_W-1:0]  lo,
	input  logic [STAMP_W-1:0]  hi,
	input  tok_t                tok_in,
	input  logic [VEC_BITS-1:0] x_in,
	input  logic [IDX_BITS-1:0] p_in,
	input  logic [RANK_W-1:0]   cnt_in,
	output tok_t                tok_out,
	output logic [VEC_BITS-1:0] x_out,
	output logic [IDX_BITS-1:0] p_out,
	output logic [RANK_W-1:0]   cnt_out
);

	logic [VEC_BITS-1:0] row_q, row_n, x_n;
	logic [IDX_BITS-1:0] stamp_q, stamp_n, p_n;
	logic [STAMP_W-1:0]  stamp_ext;
	logic                used, in_rng, is_query;
	tok_t                tok_n;
	logic [RANK_W-1:0]   cnt_n;

	assign used      = row_q[POS];
	assign stamp_ext = STAMP_W'(stamp_q);
	assign in_rng    = used && (stamp_ext >= lo) && (stamp_ext <= hi);
	assign is_query  = (cmd == CMD_CONTAINS) || (cmd == CMD_WAYS);

	always_comb begin
		row_n   = row_q;
		stamp_n = stamp_q;
		x_n     = x_in;
		p_n     = p_in;
		tok_n   = tok_in;
		cnt_n   = cnt_in;
		if (tok_in.valid && is_query && in_rng) begin
			cnt_n = cnt_in + RANK_W'(1);
		end
		if (tok_in.valid && tok_in.alive && x_in[POS]) begin
			case (cmd)
				CMD_INSERT: begin
					if (!used) begin
						row_n          = x_in;
						stamp_n        = p_in;
						tok_n.inserted = 1'b1;
						tok_n.alive    = 1'b0;
					end else if (stamp_q < p_in) begin
						// The newer vector takes the row; the old row, XORed with it, carries on down.
						row_n   = x_in;
						stamp_n = p_in;
						p_n     = stamp_q;
						x_n     = row_q ^ x_in;
					end else begin
						x_n = x_in ^ row_q;
					end
				end
				CMD_CONTAINS, CMD_WAYS: begin
					if (!in_rng) begin
						tok_n.ok    = 1'b0;
						tok_n.alive = 1'b0;
					end else begin
						x_n = x_in ^ row_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			stamp_q <= '0;
			tok_out <= '0;
		end else begin
			row_q   <= row_n;
			stamp_q <= stamp_n;
			tok_out <= tok_n;
		end
	end

	always_ff @(posedge clk) begin
		x_out   <= x_n;
		p_out   <= p_n;
		cnt_out <= cnt_n;
	end

endmodule

// File: hw/rtl/tsxb_pow.sv
// Modular power of two by square and multiply, each product formed bit-serially with
// interleaved reduction. Depends on tsxb_pkg.
module tsxb_pow import tsxb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [EXP_W-1:0]   expo,
	input  logic [MOD_W-1:0]   modulus,
	output logic               done,
	output logic [MOD_W-1:0]   result
);

	typedef enum logic [1:0] {P_IDLE, P_TEST, P_MUL} pstate_t;

	localparam int J_W = $clog2(MOD_W);

	pstate_t            state_q;
	logic [MOD_W-1:0]   r_q, b_q, ar_q, ab_q, ar_n, ab_n;
	logic [EXP_W-1:0]   e_q;
	logic [J_W-1:0]     j_q;

	// One step of a*b mod m: double, reduce, add, reduce.
	function automatic logic [MOD_W-1:0] mstep(input logic [MOD_W-1:0] acc,
		input logic [MOD_W-1:0] add, input logic bit_v, input logic [MOD_W-1:0] m);
		logic [MOD_W+1:0] t;
		logic [MOD_W+1:0] mm;
		mm = (MOD_W+2)'(m);
		t  = {1'b0, acc, 1'b0};
		if (t >= mm) t = t - mm;
		if (bit_v) t = t + (MOD_W+2)'(add);
		if (t >= mm) t = t - mm;
		return t[MOD_W-1:0];
	endfunction

	assign ar_n   = mstep(ar_q, r_q, b_q[j_q], modulus);
	assign ab_n   = mstep(ab_q, b_q, b_q[j_q], modulus);
	assign result = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						state_q <= P_TEST;
					end
				end
				P_TEST: begin
					if (e_q == '0) begin
						done    <= 1'b1;
						state_q <= P_IDLE;
					end else begin
						state_q <= P_MUL;
					end
				end
				P_MUL: begin
					if (j_q == '0) begin
						state_q <= P_TEST;
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			P_IDLE: begin
				if (start) begin
					r_q <= MOD_W'(1);
					b_q <= (modulus == MOD_W'(2)) ? '0 : MOD_W'(2);
					e_q <= expo;
				end
			end
			P_TEST: begin
				ar_q <= '0;
				ab_q <= '0;
				j_q  <= J_W'(MOD_W - 1);
			end
			P_MUL: begin
				ar_q <= ar_n;
				ab_q <= ab_n;
				j_q  <= j_q - J_W'(1);
				if (j_q == '0) begin
					if (e_q[0]) r_q <= ar_n;
					b_q <= ab_n;
					e_q <= e_q >> 1;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/timestamped_xor_basis.sv
// Top level of the timestamped XOR basis: a chain of row cells and a modular power unit.
// Depends on tsxb_pkg, tsxb_if, tsxb_cell and tsxb_pow.
//
// Requests arrive on req (valid/ready); each one gives exactly one result on rsp.
// The block works on one request at a time. A request walks the row chain from the top
// row down, one row per cycle, before its result is formed. A ways query that is
// representable, with a modulus above 1, also runs the power unit: per exponent bit a
// test step and then a bit-serial product, and the exponent has at most 17 bits. The
// chain length sets the rate of all other requests.
// The result sits in an output register; a new request is taken while it waits, and
// the next result is held back until the receiver has taken the previous one.
// Reset clears all rows, stamps, the rank and the last index at once, and sets the
// modulus to 1000000007. cfg_we writes the modulus; write it only while idle.
module timestamped_xor_basis import tsxb_pkg::*; #(
	parameter int VEC_BITS = VEC_BITS_DEF,
	parameter int IDX_BITS = IDX_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MOD_W-1:0]  cfg_wdata,
	tsxb_req_if.sink          req,
	tsxb_rsp_if.source        rsp
);

	typedef enum logic [1:0] {S_IDLE, S_CHAIN, S_POW, S_DONE} state_t;

	state_t               state_q;
	logic [MOD_W-1:0]     modulus_q;
	logic [RANK_W-1:0]    rank_q;
	logic [IDX_BITS-1:0]  last_q;
	cmd_t                 cmd_q;
	logic [STAMP_W-1:0]   lo_q, hi_q;
	tok_t                 launch_q;
	logic [VEC_BITS-1:0]  x_q;
	logic [IDX_BITS-1:0]  p_q;
	logic                 pend_ins_q, pend_rep_q;
	logic [MOD_W-1:0]     pend_ways_q;

	tok_t                 tok   [0:VEC_BITS];
	logic [VEC_BITS-1:0]  xv    [0:VEC_BITS];
	logic [IDX_BITS-1:0]  pv    [0:VEC_BITS];
	logic [RANK_W-1:0]    cv    [0:VEC_BITS];

	logic                 accept, out_free, pow_start, pow_done;
	logic [MOD_W-1:0]     pow_res;
	logic [STAMP_W-1:0]   idx_ext, last_ext, rh_ext;
	logic [IDX_BITS-1:0]  idx_m, p_new, last_new;
	logic                 end_valid, end_rep, end_ins, is_query;
	logic [EXP_W:0]       e_raw;
	logic [EXP_W-1:0]     e_clamp;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !rsp.valid || rsp.ready;

	assign idx_ext  = STAMP_W'(req.item_index);
	assign idx_m    = idx_ext[IDX_BITS-1:0];
	assign last_ext = STAMP_W'(last_q);
	assign rh_ext   = STAMP_W'(req.range_high);

	always_comb begin
		if (idx_m == '0) begin
			p_new    = (last_q != '1) ? last_q + IDX_BITS'(1) : last_q;
			last_new = p_new;
		end else begin
			p_new    = idx_m;
			last_new = (idx_m > last_q) ? idx_m : last_q;
		end
	end

	assign tok[0] = launch_q;
	assign xv[0]  = x_q;
	assign pv[0]  = p_q;
	assign cv[0]  = '0;

	for (genvar k = 0; k < VEC_BITS; k++) begin : g_cell
		tsxb_cell #(
			.VEC_BITS (VEC_BITS),
			.IDX_BITS (IDX_BITS),
			.POS      (VEC_BITS - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd_q),
			.lo      (lo_q),
			.hi      (hi_q),
			.tok_in  (tok[k]),
			.x_in    (xv[k]),
			.p_in    (pv[k]),
			.cnt_in  (cv[k]),
			.tok_out (tok[k+1]),
			.x_out   (xv[k+1]),
			.p_out   (pv[k+1]),
			.cnt_out (cv[k+1])
		);
	end

	assign is_query  = (cmd_q == CMD_CONTAINS) || (cmd_q == CMD_WAYS);
	assign end_valid = tok[VEC_BITS].valid;
	assign end_ins   = (cmd_q == CMD_INSERT) && tok[VEC_BITS].inserted;
	assign end_rep   = is_query && tok[VEC_BITS].ok && (xv[VEC_BITS] == '0);

	assign e_raw   = (EXP_W+1)'(hi_q) - (EXP_W+1)'(lo_q) + (EXP_W+1)'(1)
		- (EXP_W+1)'(cv[VEC_BITS]);
	assign e_clamp = e_raw[EXP_W] ? '0 : e_raw[EXP_W-1:0];

	assign pow_start = (state_q == S_CHAIN) && end_valid && (cmd_q == CMD_WAYS)
		&& end_rep && (modulus_q > MOD_W'(1));

	tsxb_pow u_pow (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (pow_start),
		.expo    (e_clamp),
		.modulus (modulus_q),
		.done    (pow_done),
		.result  (pow_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			modulus_q <= MOD_RESET;
			rank_q    <= '0;
			last_q    <= '0;
			launch_q  <= '0;
			rsp.valid <= 1'b0;
		end else begin
			if (cfg_we) modulus_q <= cfg_wdata;
			if (!accept) launch_q.valid <= 1'b0;
			if (rsp.valid && rsp.ready && (state_q != S_DONE)) rsp.valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						launch_q <= '{valid: 1'b1, alive: 1'b1, ok: 1'b1, inserted: 1'b0};
						if (req.cmd == 2'(CMD_INSERT)) last_q <= last_new;
						state_q <= S_CHAIN;
					end
				end
				S_CHAIN: begin
					if (end_valid) begin
						if (end_ins) rank_q <= rank_q + RANK_W'(1);
						state_q <= pow_start ? S_POW : S_DONE;
					end
				end
				S_POW: begin
					if (pow_done) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						rsp.valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(req.cmd);
			x_q   <= req.vector[VEC_BITS-1:0];
			p_q   <= p_new;
			lo_q  <= STAMP_W'(req.range_low);
			hi_q  <= (req.range_high == '0) ? last_ext : rh_ext;
		end
		if ((state_q == S_CHAIN) && end_valid) begin
			pend_ins_q  <= end_ins;
			pend_rep_q  <= end_rep;
			pend_ways_q <= '0;
		end
		if ((state_q == S_POW) && pow_done) pend_ways_q <= pow_res;
		if ((state_q == S_DONE) && out_free) begin
			rsp.inserted      <= pend_ins_q;
			rsp.representable <= pend_rep_q;
			rsp.ways_count    <= pend_ways_q;
			rsp.rank_now      <= rank_q;
			rsp.last_seen     <= last_ext[FIELD_W-1:0];
		end
	end

`ifndef SYNTHESIS
	// A token leaves the chain only while the sequencer waits for it.
	a_chain_end: assert property (@(posedge clk) disable iff (!arst_n)
		end_valid |-> (state_q == S_CHAIN))
		else $error("token left the chain outside the chain phase");

	// The power unit finishes only while the sequencer waits for it.
	a_pow_done: assert property (@(posedge clk) disable iff (!arst_n)
		pow_done |-> (state_q == S_POW))
		else $error("power unit finished outside the power phase");

	// The rank never exceeds the number of rows.
	a_rank: assert property (@(posedge clk) disable iff (!arst_n)
		rank_q <= RANK_W'(VEC_BITS))
		else $error("rank exceeds the number of rows");

	// A transfer launches exactly one token into the chain.
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> launch_q.valid ##1 !launch_q.valid)
		else $error("request transfer did not launch a single token");
`endif

endmodule

// File: tb/tsxb_chk.sv
// Checker for the timestamped XOR basis: watches both channels and the modulus write port.
// Keeps its own copy of the basis and compares each result with the oldest prediction.
// Depends on tsxb_pkg and tsxb_if.
module tsxb_chk import tsxb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [MOD_W-1:0] cfg_wdata,
	tsxb_req_if              req,
	tsxb_rsp_if              rsp,
	output int               fails,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               inserted;
		logic               representable;
		logic [MOD_W-1:0]   ways_count;
		logic [RANK_W-1:0]  rank_now;
		logic [FIELD_W-1:0] last_seen;
	} outcome_t;

	outcome_t           outcome_q[$];
	logic [VEC_W-1:0]   rows[64];
	logic [FIELD_W-1:0] stamps[64];
	logic [RANK_W-1:0]  rank_c;
	logic [FIELD_W-1:0] last_idx;
	logic [MOD_W-1:0]   mod_v;

	assign pending = outcome_q.size();

	function automatic bit row_in(int i, int lo, int hi);
		return rows[i][i] && int'(stamps[i]) >= lo && int'(stamps[i]) <= hi;
	endfunction

	function automatic bit spanned(logic [VEC_W-1:0] x, int lo, int hi);
		for (int i = VEC_W - 1; i >= 0; i--) begin
			if (x[i]) begin
				if (!row_in(i, lo, hi))
					return 0;
				x ^= rows[i];
			end
		end
		return x == '0;
	endfunction

	function automatic logic [MOD_W-1:0] pow_two(longint e, longint unsigned m);
		longint unsigned r, b;
		r = 1 % m;
		b = 2 % m;
		while (e > 0) begin
			if (e[0])
				r = (r * b) % m;
			b = (b * b) % m;
			e = e >> 1;
		end
		return r[MOD_W-1:0];
	endfunction

	function automatic bit insert_row(logic [VEC_W-1:0] x, logic [FIELD_W-1:0] idx);
		logic [FIELD_W-1:0] p, ts;
		logic [VEC_W-1:0]   tv;
		if (idx == '0) begin
			if (last_idx != '1)
				last_idx++;
			p = last_idx;
		end else begin
			if (idx > last_idx)
				last_idx = idx;
			p = idx;
		end
		for (int i = VEC_W - 1; i >= 0; i--) begin
			if (x[i]) begin
				if (!rows[i][i]) begin
					rows[i] = x;
					stamps[i] = p;
					rank_c++;
					return 1;
				end
				// A newer vector displaces an older row and carries on with it.
				if (stamps[i] < p) begin
					ts = stamps[i];
					tv = rows[i];
					stamps[i] = p;
					rows[i] = x;
					p = ts;
					x = tv;
				end
				x ^= rows[i];
			end
		end
		return 0;
	endfunction

	function automatic outcome_t predict(logic [1:0] cmd, logic [VEC_W-1:0] x,
		logic [FIELD_W-1:0] idx, logic [FIELD_W-1:0] rlo, logic [FIELD_W-1:0] rhi);
		outcome_t o;
		int lo, hi, m;
		longint e;
		o = '0;
		lo = int'(rlo);
		hi = (rhi == '0) ? int'(last_idx) : int'(rhi);
		case (cmd)
			CMD_INSERT: begin
				o.inserted = insert_row(x, idx);
			end
			CMD_CONTAINS: begin
				o.representable = spanned(x, lo, hi);
			end
			CMD_WAYS: begin
				o.representable = spanned(x, lo, hi);
				if (o.representable && mod_v > 1) begin
					m = 0;
					for (int i = 0; i < VEC_W; i++)
						if (row_in(i, lo, hi))
							m++;
					e = hi - lo + 1 - m;
					if (e < 0)
						e = 0;
					o.ways_count = pow_two(e, mod_v);
				end
			end
			default: ;
		endcase
		o.rank_now = rank_c;
		o.last_seen = last_idx;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < 64; i++) begin
				rows[i] = '0;
				stamps[i] = '0;
			end
			rank_c = '0;
			last_idx = '0;
			mod_v = MOD_RESET;
			fails = 0;
			outcome_q.delete();
		end else begin
			if (cfg_we)
				mod_v = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				got = {rsp.inserted, rsp.representable, rsp.ways_count, rsp.rank_now,
					rsp.last_seen};
				if (outcome_q.size() == 0) begin
					fails++;
					$display("%0t: result transfer with nothing expected: %h", $realtime, got);
				end else begin
					want = outcome_q.pop_front();
					if (want.inserted !== got.inserted) begin
						fails++;
						$display("%0t: inserted expected %b actual %b", $realtime,
							want.inserted, got.inserted);
					end
					if (want.representable !== got.representable) begin
						fails++;
						$display("%0t: representable expected %b actual %b", $realtime,
							want.representable, got.representable);
					end
					if (want.ways_count !== got.ways_count) begin
						fails++;
						$display("%0t: ways_count expected %0d actual %0d", $realtime,
							want.ways_count, got.ways_count);
					end
					if (want.rank_now !== got.rank_now) begin
						fails++;
						$display("%0t: rank_now expected %0d actual %0d", $realtime,
							want.rank_now, got.rank_now);
					end
					if (want.last_seen !== got.last_seen) begin
						fails++;
						$display("%0t: last_seen expected %0d actual %0d", $realtime,
							want.last_seen, got.last_seen);
					end
				end
			end
			if (req.valid && req.ready)
				outcome_q.push_back(predict(req.cmd, req.vector, req.item_index,
					req.range_low, req.range_high));
		end
	end

endmodule

// File: tb/timestamped_xor_basis_tb.sv
// Top of the timestamped XOR basis testbench: clock, reset, stimulus, receiver and verdict.
// Depends on tsxb_pkg, tsxb_if, the block and the tsxb_chk checker.
module timestamped_xor_basis_tb import tsxb_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [MOD_W-1:0] cfg_wdata;
	int               fails;
	int               pending;
	bit               calm;
	bit               done;
	int               quiet;
	int               cyc;
	logic [VEC_W-1:0] pool[$];
	logic [FIELD_W-1:0] sent_last;

	localparam int QUIET_LIMIT = 40000;

	tsxb_req_if req ();
	tsxb_rsp_if rsp ();

	timestamped_xor_basis i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	tsxb_chk i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Sends one request; valid stays high into the next request unless an idle gap comes.
	task automatic send(logic [1:0] cmd, logic [VEC_W-1:0] v, logic [FIELD_W-1:0] idx,
		logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
		bit rdy;
		if (!calm && $urandom_range(99) < 37) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.vector <= v;
		req.item_index <= idx;
		req.range_low <= lo;
		req.range_high <= hi;
		do begin
			@(negedge clk);
			rdy = req.ready;
			@(posedge clk);
		end while (!rdy);
		if (cmd == CMD_INSERT) begin
			if (idx == '0) begin
				if (sent_last != '1)
					sent_last++;
			end else if (idx > sent_last) begin
				sent_last = idx;
			end
			if (v != '0) begin
				pool.push_back(v);
				if (pool.size() > 48)
					void'(pool.pop_front());
			end
		end
	endtask

	task automatic write_modulus(logic [MOD_W-1:0] m);
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [VEC_W-1:0] rand_vec();
		logic [VEC_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(4))
			0: return v;
			1: return v & 64'h0000_0000_0000_00FF;
			2: return v & 64'hF000_0000_0000_0F0F;
			3: return v & 64'h8000_0000_0000_0001;
			default: return v & ({VEC_W{1'b1}} >> $urandom_range(VEC_W - 1));
		endcase
	endfunction

	// Mostly sums of inserted vectors, so that queries hit the basis.
	function automatic logic [VEC_W-1:0] query_vec();
		logic [VEC_W-1:0] v;
		v = '0;
		if (pool.size() == 0 || $urandom_range(3) == 0)
			return rand_vec();
		repeat ($urandom_range(1, 4))
			v ^= pool[$urandom_range(pool.size() - 1)];
		return v;
	endfunction

	task automatic random_items(int n);
		logic [FIELD_W-1:0] idx, lo, hi;
		int k;
		for (int j = 0; j < n; j++) begin
			k = $urandom_range(99);
			idx = '0;
			if (k < 8)
				idx = FIELD_W'($urandom);
			else if (k < 30)
				idx = FIELD_W'(sent_last + $urandom_range(0, 3));
			lo = (sent_last > 40) ? FIELD_W'(sent_last - $urandom_range(40))
				: FIELD_W'($urandom_range(3));
			hi = ($urandom_range(2) == 0) ? '0 : FIELD_W'(lo + $urandom_range(45));
			if (k >= 96) begin
				lo = FIELD_W'($urandom);
				hi = FIELD_W'($urandom);
			end
			k = $urandom_range(99);
			if (k < 45)
				send(CMD_INSERT, rand_vec(), idx, lo, hi);
			else if (k < 70)
				send(CMD_CONTAINS, query_vec(), idx, lo, hi);
			else if (k < 97)
				send(CMD_WAYS, query_vec(), idx, lo, hi);
			else
				send(CMD_UNUSED, rand_vec(), idx, lo, hi);
		end
	endtask

	// Receiver: random stalls, a calm stretch, and one long hold-off to back up the input.
	initial begin
		rsp.ready = 1'b0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 30000) begin
				rsp.ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else begin
				rsp.ready <= calm || $urandom_range(99) >= 37;
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n || done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("timestamped_xor_basis regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.cmd = '0;
		req.vector = '0;
		req.item_index = '0;
		req.range_low = '0;
		req.range_high = '0;
		calm = 0;
		done = 0;
		sent_last = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first under the reset modulus, then under moduli 1, 0x7FFFFFFF and 2.
		send(CMD_CONTAINS, '0, '0, 16'd5, 16'd2);
		send(CMD_CONTAINS, 64'h1, '0, 16'd5, 16'd2);
		send(CMD_INSERT, '0, '0, '0, '0);
		send(CMD_INSERT, '1, '0, '0, '0);
		send(CMD_INSERT, 64'h8000_0000_0000_0000, '0, '0, '0);
		send(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, '0);
		send(CMD_INSERT, 64'h1, 16'd10, '0, '0);
		send(CMD_INSERT, 64'h3, '0, '0, '0);
		send(CMD_INSERT, 64'h2, 16'd4, '0, '0);
		send(CMD_CONTAINS, 64'h1, '0, '0, '0);
		send(CMD_CONTAINS, '1, 16'd2, 16'd2, 16'd2);
		send(CMD_WAYS, 64'h1, '0, 16'd1, 16'd3);
		send(CMD_WAYS, '0, '0, '0, 16'hFFFF);
		send(CMD_WAYS, '1, '0, 16'd11, '0);
		send(CMD_UNUSED, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(CMD_INSERT, 64'h5555_AAAA_5555_AAAA, 16'hFFFF, '0, '0);
		send(CMD_INSERT, 64'h0F0F, '0, '0, '0);
		send(CMD_WAYS, 64'h0F0F, '0, 16'hFFFF, '0);
		send(CMD_WAYS, '0, '0, '0, '0);

		write_modulus(31'd1);
		send(CMD_WAYS, '0, '0, '0, 16'd20);
		send(CMD_WAYS, 64'h1, '0, '0, '0);
		write_modulus(31'h7FFF_FFFF);
		send(CMD_WAYS, '0, '0, '0, '0);
		send(CMD_WAYS, 64'h0F0F, '0, '0, 16'd300);
		write_modulus(31'd2);
		send(CMD_WAYS, '0, '0, 16'd3, 16'd3);

		// Random part: several modulus settings, with a calm stretch in the middle.
		write_modulus(MOD_RESET);
		random_items(300);
		calm = 1;
		random_items(150);
		calm = 0;
		write_modulus(31'd2);
		random_items(150);
		write_modulus(31'h7FFF_FFFF);
		random_items(250);
		write_modulus(31'd1);
		random_items(100);
		write_modulus(MOD_W'($urandom_range(2, 31'h7FFF_FFFF)));
		random_items(350);
		req.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		done = 1;
		repeat (1200) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("timestamped_xor_basis regression: pass");
		else
			$display("timestamped_xor_basis regression: fail");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/tsxb_pkg.sv
hw/rtl/tsxb_if.sv
hw/rtl/tsxb_cell.sv
hw/rtl/tsxb_pow.sv
hw/rtl/timestamped_xor_basis.sv
tb/tsxb_chk.sv
tb/timestamped_xor_basis_tb.sv
